// ===== rtl/bffr_pkg.sv =====
// Package for the first-fit run allocator: payload structs, sequencer state,
// scan mode and fixed field widths. No dependencies.
`default_nettype none
package bffr_pkg;

  localparam int WORD_BITS = 32;
  localparam int OFF_W     = 5;
  localparam int CNT_W     = 6;
  localparam int NEED_W    = 13;
  localparam int START_W   = 12;
  localparam int UNITS_W   = 13;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic       OP_FORMAT        = 1'b0;
  localparam logic       OP_ALLOC         = 1'b1;
  localparam logic [0:0] REG_USABLE_UNITS = 1'b0;

  typedef struct packed {
    logic              operation;
    logic [NEED_W-1:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [START_W-1:0] start_index;
    logic               ok;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FORMAT,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESP
  } ctrl_state_t;

  typedef enum logic {
    MODE_USED,
    MODE_FREE
  } scan_mode_t;

endpackage
`default_nettype wire

// ===== rtl/bffr_map_ram.sv =====
// Usage map storage: one write port, one read port with registered read data.
// Depends on bffr_pkg for the word width.
`default_nettype none
module bffr_map_ram
  import bffr_pkg::*;
#(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_W-1:0]    raddr,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/bffr_run_counter.sv =====
// Shared scan unit: shift a map word down to the cursor and count the run of
// used or free bits that starts there. Depends on bffr_pkg.
`default_nettype none
module bffr_run_counter
  import bffr_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [OFF_W-1:0]     offset,
  input  wire scan_mode_t           mode,
  output logic      [CNT_W-1:0]     count
);

  logic [WORD_BITS:0] operand;

  always_comb begin
    operand = {1'b1, (mode == MODE_USED) ? ~word : word} >> offset;
    count   = CNT_W'(WORD_BITS);
    for (int i = WORD_BITS; i >= 0; i--) begin
      if (operand[i]) begin
        count = CNT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bffr_ctrl.sv =====
// Sequencer for reset clear, format, first-fit scan and run marking over the
// usage map, plus the result register. Depends on bffr_pkg only.
`default_nettype none
module bffr_ctrl
  import bffr_pkg::*;
#(
  parameter int MAP_UNITS = 4096,
  parameter int NW        = 128,
  parameter int AW        = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic [UNITS_W-1:0]   usable_units,
  output logic                      ram_we,
  output logic      [AW-1:0]        ram_waddr,
  output logic      [WORD_BITS-1:0] ram_wdata,
  output logic                      ram_re,
  output logic      [AW-1:0]        ram_raddr,
  input  wire logic [WORD_BITS-1:0] ram_rdata,
  output logic      [OFF_W-1:0]     scan_off,
  output scan_mode_t                scan_mode,
  input  wire logic [CNT_W-1:0]     scan_cnt
);

  localparam int PW  = AW + OFF_W;
  localparam int PW1 = PW + 1;
  localparam int LW  = $clog2(MAP_UNITS + 1);
  localparam int CW  = (LW > NEED_W) ? LW : NEED_W;
  localparam int XW  = (PW > LW) ? PW : LW;
  localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

  ctrl_state_t          state_r, state_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  scan_mode_t           mode_r, mode_nxt;
  logic [LW-1:0]        run_len_r, run_len_nxt;
  logic [PW-1:0]        run_start_r, run_start_nxt;
  logic [PW-1:0]        start_r, start_nxt;
  logic [PW-1:0]        last_r, last_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic [LW-1:0]        limit_r, limit_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic [WORD_BITS-1:0] fmt_word;
  logic [WORD_BITS-1:0] mark_mask;
  logic [CNT_W-1:0]     pos_end;
  logic                 at_end;
  logic [PW-1:0]        cur_pos;
  logic [PW-1:0]        run_begin;
  logic [LW-1:0]        new_len;
  logic [CW-1:0]        need_eff;
  logic                 hit;
  logic                 too_long;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pos_end   = CNT_W'(off_r) + scan_cnt;
  assign at_end    = pos_end[CNT_W-1];
  assign cur_pos   = {word_r, off_r};
  assign run_begin = (run_len_r == '0) ? cur_pos : run_start_r;
  assign new_len   = run_len_r + LW'(scan_cnt);
  assign need_eff  = (need_r == '0) ? CW'(1) : CW'(need_r);
  assign hit       = CW'(new_len) >= need_eff;
  assign too_long  = CW'(in_data.run_length) > CW'(MAP_UNITS);
  assign scan_off  = off_r;
  assign scan_mode = mode_r;

  always_comb begin
    logic [XW-1:0] idx;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx         = XW'({word_r, OFF_W'(j)});
      fmt_word[j] = (idx == '0) || (idx >= XW'(limit_r));
    end
  end

  always_comb begin
    logic [OFF_W-1:0] lo;
    logic [OFF_W-1:0] hi;
    lo = (word_r == start_r[PW-1:OFF_W]) ? start_r[OFF_W-1:0] : '0;
    hi = (word_r == last_r[PW-1:OFF_W]) ? last_r[OFF_W-1:0] : '1;
    mark_mask = ({WORD_BITS{1'b1}} << lo) &
                ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - hi));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (word_r == LAST_WORD) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.operation == OP_FORMAT) begin
            state_nxt = ST_FORMAT;
          end else if (too_long) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_FORMAT: begin
        if (word_r == LAST_WORD) state_nxt = ST_RESP;
      end
      ST_SCAN_RD: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (mode_r == MODE_FREE && hit) begin
          state_nxt = (need_r == '0) ? ST_RESP : ST_MARK_RD;
        end else if ((mode_r == MODE_USED || at_end) && at_end && word_r == LAST_WORD) begin
          state_nxt = ST_RESP;
        end
      end
      ST_MARK_RD: state_nxt = ST_MARK_WR;
      ST_MARK_WR: begin
        if (word_r == last_r[PW-1:OFF_W]) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    word_nxt      = word_r;
    off_nxt       = off_r;
    mode_nxt      = mode_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    start_nxt     = start_r;
    last_nxt      = last_r;
    need_nxt      = need_r;
    limit_nxt     = limit_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    in_stall      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = fmt_word;
    ram_re        = 1'b0;
    ram_raddr     = word_r;
    case (state_r)
      ST_CLEAR, ST_FORMAT: begin
        ram_we   = 1'b1;
        word_nxt = word_r + AW'(1);
        start_nxt = '0;
        ok_nxt    = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        word_nxt    = '0;
        off_nxt     = '0;
        mode_nxt    = MODE_USED;
        run_len_nxt = '0;
        start_nxt   = '0;
        ok_nxt      = 1'b0;
        need_nxt    = in_data.run_length;
        if (in_accept && in_data.operation == OP_FORMAT) begin
          if (CW'(usable_units) > CW'(MAP_UNITS)) begin
            limit_nxt = LW'(MAP_UNITS);
          end else begin
            limit_nxt = LW'(usable_units);
          end
        end
      end
      ST_SCAN_RD: begin
        ram_re = 1'b1;
      end
      ST_SCAN: begin
        if (mode_r == MODE_FREE) begin
          run_start_nxt = run_begin;
          if (hit) begin
            start_nxt = run_begin;
            ok_nxt    = 1'b1;
          end else if (at_end) begin
            run_len_nxt = new_len;
            word_nxt    = word_r + AW'(1);
            off_nxt     = '0;
            ram_re      = 1'b1;
            ram_raddr   = word_r + AW'(1);
          end else begin
            run_len_nxt = '0;
            off_nxt     = pos_end[OFF_W-1:0];
            mode_nxt    = MODE_USED;
          end
        end else begin
          if (at_end) begin
            word_nxt  = word_r + AW'(1);
            off_nxt   = '0;
            ram_re    = 1'b1;
            ram_raddr = word_r + AW'(1);
          end else begin
            off_nxt  = pos_end[OFF_W-1:0];
            mode_nxt = MODE_FREE;
          end
        end
      end
      ST_MARK_RD: begin
        last_nxt  = PW'(PW1'(start_r) + PW1'(need_r) - PW1'(1));
        word_nxt  = start_r[PW-1:OFF_W];
        ram_re    = 1'b1;
        ram_raddr = start_r[PW-1:OFF_W];
      end
      ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | mark_mask;
        word_nxt  = word_r + AW'(1);
        ram_re    = 1'b1;
        ram_raddr = word_r + AW'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.start_index = ok_r ? START_W'(start_r) : '0;
          out_data_nxt.ok          = ok_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      word_r      <= '0;
      limit_r     <= LW'(MAP_UNITS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r       <= off_nxt;
    mode_r      <= mode_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    start_r     <= start_nxt;
    last_r      <= last_nxt;
    need_r      <= need_nxt;
    ok_r        <= ok_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/bitmap_first_fit_run_allocator_top.sv =====
// Format: one write per map word, then the result register loads.
// Allocate: the scan reads map words and steps over used/free run boundaries until a
// free run is long enough, then reads and marks that run's words; a failed or
// zero-length request skips marking, and an oversized one skips the scan as well.
// Next transaction accepted in the same cycle the result is first presented.
// Reset: a clearing pass writes every map word; usable_units -> 4096.
`default_nettype none
module bitmap_first_fit_run_allocator_top
  import bffr_pkg::*;
#(
  parameter int MAP_UNITS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int NW = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;

  logic [UNITS_W-1:0]   usable_units_r;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [OFF_W-1:0]     scan_off;
  scan_mode_t           scan_mode;
  logic [CNT_W-1:0]     scan_cnt;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_units_r <= UNITS_W'(4096);
    end else if (psel && penable && pwrite && paddr[2] == REG_USABLE_UNITS) begin
      usable_units_r <= pwdata[UNITS_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_USABLE_UNITS) begin
      prdata = APB_DW'(usable_units_r);
    end else begin
      prdata = '0;
    end
  end

  bffr_map_ram #(
    .DEPTH  (NW),
    .ADDR_W (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bffr_run_counter u_run_counter (
    .word   (ram_rdata),
    .offset (scan_off),
    .mode   (scan_mode),
    .count  (scan_cnt)
  );

  bffr_ctrl #(
    .MAP_UNITS (MAP_UNITS),
    .NW        (NW),
    .AW        (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .usable_units (usable_units_r),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .scan_off     (scan_off),
    .scan_mode    (scan_mode),
    .scan_cnt     (scan_cnt)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_bitmap_first_fit_run_allocator_top.sv =====
// Testbench for bitmap_first_fit_run_allocator_top: directed and random format/allocate
// transactions checked against an in-bench usage-map predictor, with APB setup of usable_units.
// Depends on bffr_pkg and the allocator RTL only.
`timescale 1ns / 100ps
module tb_bitmap_first_fit_run_allocator_top
  import bffr_pkg::*;
();

  localparam int MAP_UNITS      = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_REPORTS    = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bit                unit_used [MAP_UNITS];
  logic [UNITS_W-1:0] usable_model;
  out_item_t         pending_results[$];
  out_item_t         oldest_result;
  int                mismatches;
  int                quiet_cycles;
  int                sender_idle_pct;
  int                receiver_stall_pct;
  int                hold_len;

  bitmap_first_fit_run_allocator_top #(
    .MAP_UNITS(MAP_UNITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t allocate_or_format(input in_item_t item);
    out_item_t res;
    int        limit;
    int        pos;
    int        fin;
    int        need;
    bit        found;
    res.start_index = '0;
    res.ok          = 1'b0;
    if (item.operation == OP_FORMAT) begin
      limit = (usable_model > MAP_UNITS) ? MAP_UNITS : int'(usable_model);
      unit_used[0] = 1'b1;
      for (int i = 1; i < MAP_UNITS; i++) unit_used[i] = (i >= limit);
      res.ok = 1'b1;
      return res;
    end
    need  = int'(item.run_length);
    found = 1'b0;
    pos   = 0;
    if (need <= MAP_UNITS) begin
      while (pos < MAP_UNITS && !found) begin
        while (pos < MAP_UNITS && unit_used[pos]) pos++;
        if (pos >= MAP_UNITS) break;
        fin = pos;
        while (fin < MAP_UNITS && !unit_used[fin]) fin++;
        if (fin - pos >= need) found = 1'b1;
        else pos = fin;
      end
    end
    if (found) begin
      for (int i = 0; i < need; i++) unit_used[pos + i] = 1'b1;
      res.start_index = pos[START_W-1:0];
      res.ok          = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input out_item_t exp_r,
                                 input out_item_t act_r);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected start_index=%0d ok=%0b, got start_index=%0d ok=%0b",
               $realtime, what, exp_r.start_index, exp_r.ok, act_r.start_index, act_r.ok);
  endtask

  // check results and watch for a hung handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction", '0, out_data);
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_data.start_index !== oldest_result.start_index)
            report_mismatch("start_index", oldest_result, out_data);
          else if (out_data.ok !== oldest_result.ok)
            report_mismatch("ok", oldest_result, out_data);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("bitmap_first_fit_run_allocator_top test failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(allocate_or_format(item));
    @(negedge clk);
  endtask

  task automatic send_op(input logic op, input int len);
    in_item_t item;
    item.operation  = op;
    item.run_length = len[NEED_W-1:0];
    send_item(item);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_usable(input int value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'(REG_USABLE_UNITS) << 2;
    pwdata  = APB_DW'(value[UNITS_W-1:0]);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    usable_model = value[UNITS_W-1:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[UNITS_W-1:0] !== usable_model) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: usable_units readback: expected %0d, got %0d",
                 $realtime, usable_model, prdata[UNITS_W-1:0]);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_reset_map();
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 1);
    send_op(OP_ALLOC, MAP_UNITS);
    send_op(OP_ALLOC, 8191);
    send_op(OP_ALLOC, MAP_UNITS - 2);
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 1);
    send_op(OP_FORMAT, 8191);
    send_op(OP_ALLOC, MAP_UNITS - 1);
    wait_idle();
  endtask

  task automatic test_format_limits();
    write_usable(0);
    send_op(OP_FORMAT, 0);
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 1);
    wait_idle();
    write_usable(1);
    send_op(OP_FORMAT, 0);
    send_op(OP_ALLOC, 1);
    wait_idle();
    write_usable(2);
    send_op(OP_FORMAT, 0);
    send_op(OP_ALLOC, 1);
    send_op(OP_ALLOC, 1);
    wait_idle();
    write_usable(8191);
    send_op(OP_FORMAT, 0);
    send_op(OP_ALLOC, MAP_UNITS - 1);
    wait_idle();
    write_usable(MAP_UNITS);
    send_op(OP_FORMAT, 0);
    send_op(OP_ALLOC, 3000);
    send_op(OP_ALLOC, 1095);
    send_op(OP_ALLOC, 1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_op(OP_FORMAT, 0);
    hold_len = 500;
    repeat (10) send_op(OP_ALLOC, $urandom_range(40, 1));
    wait_idle();
  endtask

  task automatic test_random_runs(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int units;
    int span;
    int pick;
    in_item_t item;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      pick = $urandom_range(9);
      if (pick == 0) units = 0;
      else if (pick == 1) units = 1;
      else if (pick == 2) units = 2;
      else if (pick == 3) units = MAP_UNITS;
      else if (pick == 4) units = $urandom_range(8191, MAP_UNITS + 1);
      else if (pick <= 6) units = $urandom_range(MAP_UNITS, 3);
      else units = $urandom_range(400, 3);
      write_usable(units);
      item.operation  = OP_FORMAT;
      item.run_length = NEED_W'($urandom);
      send_item(item);
      sent++;
      span = (units > MAP_UNITS) ? MAP_UNITS : units;
      span = (span / 8 < 1) ? 1 : span / 8;
      repeat ($urandom_range(60, 20)) begin
        pick = $urandom_range(99);
        item.operation = (pick < 5) ? OP_FORMAT : OP_ALLOC;
        if (pick < 10) item.run_length = NEED_W'($urandom);
        else if (pick < 15) item.run_length = '0;
        else item.run_length = NEED_W'($urandom_range(span, 1));
        send_item(item);
        sent++;
      end
    end
    wait_idle();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_stall          = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    mismatches         = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_len           = 0;
    usable_model       = UNITS_W'(MAP_UNITS);
    for (int i = 0; i < MAP_UNITS; i++) unit_used[i] = (i == 0);
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_map();
    test_format_limits();
    test_backpressure();
    test_random_runs(450, 0, 0);
    test_random_runs(450, 68, 0);
    test_random_runs(450, 0, 68);
    test_random_runs(400, 32, 32);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("bitmap_first_fit_run_allocator_top test passed");
    end else begin
      $display("bitmap_first_fit_run_allocator_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bffr_pkg.sv
rtl/bffr_map_ram.sv
rtl/bffr_run_counter.sv
rtl/bffr_ctrl.sv
rtl/bitmap_first_fit_run_allocator_top.sv
tb/sv/tb_bitmap_first_fit_run_allocator_top.sv
